[design/itf_pkg.sv]
// ----------------------------------------------------------------------------
// itf_pkg: shared definitions for the integer to text formatter
// Sizes, conversion codes, ASCII codes, the digit unit control group and the
// digit to character function.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

   // value width and pad limit
   localparam int VALUE_BITS = 64;
   localparam int MAX_PAD    = 120;

   // digit counts per radix for a VALUE_BITS wide magnitude
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
   localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int BIN_DIGITS = VALUE_BITS;

   localparam int DEC_BITS = 4 * DEC_DIGITS;
   localparam int OCT_BITS = 3 * OCT_DIGITS;
   localparam int HEX_BITS = 4 * HEX_DIGITS;

   // digit window width: widest left-aligned digit string
   localparam int DIG_W = (DEC_BITS > OCT_BITS) ?
                          ((DEC_BITS > HEX_BITS) ? DEC_BITS : HEX_BITS) :
                          ((OCT_BITS > HEX_BITS) ? OCT_BITS : HEX_BITS);

   // digit counter and text length widths
   localparam int CNT_W = $clog2(BIN_DIGITS + 1);
   localparam int LEN_W = $clog2(MAX_PAD + BIN_DIGITS + 8);

   // conversion codes
   localparam logic [2:0] OP_SDEC = 3'd0;
   localparam logic [2:0] OP_UDEC = 3'd1;
   localparam logic [2:0] OP_OCT  = 3'd2;
   localparam logic [2:0] OP_HEXL = 3'd3;
   localparam logic [2:0] OP_HEXU = 3'd4;
   localparam logic [2:0] OP_BIN  = 3'd5;

   // ASCII codes
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_X_LO  = 8'h78;
   localparam logic [7:0] CH_X_UP  = 8'h58;
   localparam logic [7:0] CH_B_LO  = 8'h62;
   localparam logic [7:0] CH_A_LO  = 8'h61;
   localparam logic [7:0] CH_A_UP  = 8'h41;

   // commands to the digit unit, at most one per cycle
   typedef struct packed {
      logic load;     // take a new magnitude
      logic step;     // one shift-add-3 iteration
      logic commit;   // move the BCD result into the digit window
      logic shift;    // drop the top digit
   } dig_ctl_type;

   // map a digit value to its ASCII code
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'b0000, d};
      end else begin
         c = (upper ? CH_A_UP : CH_A_LO) + {4'b0000, d - 4'd10};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[design/integer_to_text_formatter.sv]
// ----------------------------------------------------------------------------
// integer_to_text_formatter: printf style integer to ASCII conversion
// Formats one value per command as signed or unsigned decimal, octal, hex or
// binary text with sign, prefix and zero padding, up to four characters a beat.
// ----------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   -------   ---------------------------   --------------------------------
//   command   start, busy, req_*            taken when start & !busy
//   result    rsp_valid, rsp_*              one-cycle strobe, never stalled
//
// Sequence: decimal runs VALUE_BITS shift-add-3 steps and a commit; every
// radix then drops leading zero digits, ends the skip, counts padding, sets
// up and emits one character at a time; an undefined code goes straight to
// setup and gives the empty text beat. Busy is low after reset, which
// clears the sequencer and the result strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_text_formatter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [63:0] req_value_bits,
   input  wire logic        req_flag_left,
   input  wire logic        req_flag_plus,
   input  wire logic        req_flag_space,
   input  wire logic        req_flag_zero,
   input  wire logic        req_flag_alt,
   input  wire logic signed [7:0] req_precision,
   input  wire logic [6:0]  req_field_width,
   output logic             rsp_valid,
   output logic [31:0]      rsp_text_chars,
   output logic [2:0]       rsp_char_count,
   output logic             rsp_last_group
);
   import itf_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SKIP  = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_SETUP = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [2:0]       op_ff, op_in;
   logic             bad_ff, bad_in;
   logic             sgn_ff, sgn_in;
   logic [7:0]       sign_char_ff, sign_char_in;
   logic [7:0]       letter_ff, letter_in;
   logic             pfx_ff, pfx_in;
   logic             octz_ff, octz_in;
   logic             zpad_ff, zpad_in;
   logic             pg_ff, pg_in;
   logic [LEN_W-1:0] prec_ff, prec_in;
   logic [LEN_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] iter_ff, iter_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] zc_ff, zc_in;
   logic [LEN_W-1:0] b1_ff, b1_in;
   logic [LEN_W-1:0] b2_ff, b2_in;
   logic [LEN_W-1:0] b3_ff, b3_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [1:0]       lane_ff, lane_in;
   logic [31:0]      word_ff, word_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_text_ff, rsp_text_in;
   logic [2:0]       rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0] val;
   logic [VALUE_BITS-1:0] mag;
   logic                  neg;
   logic [7:0]            prec_raw;
   logic [7:0]            width_raw;
   logic [LEN_W-1:0]      len_a;
   logic [LEN_W-1:0]      len1;
   logic [LEN_W-1:0]      tw;
   logic                  defz;
   logic [LEN_W-1:0]      n_calc;
   logic [7:0]            ch;
   logic                  last_char;
   logic [31:0]           word_next;
   logic [3:0]            top_digit;
   dig_ctl_type           dig_ctl;

   // digit unit
   itf_digit_src u_digits (
      .clock     (clock),
      .ctl       (dig_ctl),
      .op        (state_ff == ST_IDLE ? req_opcode : op_ff),
      .mag       (mag),
      .top_digit (top_digit)
   );

   // magnitude and sign of the incoming value
   always_comb begin
      val       = req_value_bits[VALUE_BITS-1:0];
      neg       = (req_opcode == OP_SDEC) && val[VALUE_BITS-1];
      mag       = neg ? (~val + VALUE_BITS'(1)) : val;
      prec_raw  = {1'b0, req_precision[6:0]};
      width_raw = {1'b0, req_field_width};
   end

   // length before padding and the default zero digit
   always_comb begin
      len_a = LEN_W'(rem_ff) + LEN_W'(octz_ff) + ((pfx_ff && zpad_ff) ? LEN_W'(2) : '0);
      defz  = (len_a == '0);
      len1  = len_a + LEN_W'(defz);
      if (zpad_ff) begin
         tw = width_ff - LEN_W'(sgn_ff && (width_ff != '0));
      end else begin
         tw = '0;
      end
      n_calc = LEN_W'(sgn_ff) + (pfx_ff ? LEN_W'(2) : '0) + zc_ff + LEN_W'(octz_ff)
               + LEN_W'(rem_ff);
   end

   // character at the current text position
   always_comb begin
      if (pos_ff < b1_ff) begin
         ch = sign_char_ff;
      end else if (pos_ff < b2_ff) begin
         ch = (pos_ff == b1_ff) ? CH_ZERO : letter_ff;
      end else if (pos_ff < b3_ff) begin
         ch = CH_ZERO;
      end else begin
         ch = digit_char(top_digit, op_ff == OP_HEXU);
      end
      last_char = (pos_ff == n_ff - LEN_W'(1));
      word_next = word_ff | (32'(ch) << {lane_ff, 3'b000});
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      bad_in       = bad_ff;
      sgn_in       = sgn_ff;
      sign_char_in = sign_char_ff;
      letter_in    = letter_ff;
      pfx_in       = pfx_ff;
      octz_in      = octz_ff;
      zpad_in      = zpad_ff;
      pg_in        = pg_ff;
      prec_in      = prec_ff;
      width_in     = width_ff;
      iter_in      = iter_ff;
      rem_in       = rem_ff;
      zc_in        = zc_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      n_in         = n_ff;
      pos_in       = pos_ff;
      lane_in      = lane_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_text_in  = rsp_text_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      dig_ctl      = '0;

      unique case (state_ff)
         // take a command and load the digit unit
         ST_IDLE: begin
            if (start) begin
               dig_ctl.load = 1'b1;
               op_in        = req_opcode;
               bad_in       = (req_opcode > OP_BIN);
               sgn_in       = (req_opcode == OP_SDEC) &&
                              (neg || req_flag_plus || req_flag_space);
               sign_char_in = neg ? CH_MINUS : (req_flag_plus ? CH_PLUS : CH_SPACE);
               pfx_in       = req_flag_alt && (req_opcode >= OP_HEXL) &&
                              (req_opcode <= OP_BIN);
               octz_in      = req_flag_alt && (req_opcode == OP_OCT);
               zpad_in      = req_flag_zero && !req_flag_left;
               pg_in        = !req_precision[7];
               prec_in      = LEN_W'((prec_raw > 8'(MAX_PAD)) ? 8'(MAX_PAD) : prec_raw);
               width_in     = LEN_W'((width_raw > 8'(MAX_PAD)) ? 8'(MAX_PAD) : width_raw);
               iter_in      = CNT_W'(VALUE_BITS);
               case (req_opcode) inside
                  OP_SDEC, OP_UDEC: begin
                     letter_in = CH_B_LO;
                     rem_in    = CNT_W'(DEC_DIGITS);
                     state_in  = ST_CONV;
                  end
                  OP_OCT: begin
                     letter_in = CH_B_LO;
                     rem_in    = CNT_W'(OCT_DIGITS);
                     state_in  = ST_SKIP;
                  end
                  OP_HEXL: begin
                     letter_in = CH_X_LO;
                     rem_in    = CNT_W'(HEX_DIGITS);
                     state_in  = ST_SKIP;
                  end
                  OP_HEXU: begin
                     letter_in = CH_X_UP;
                     rem_in    = CNT_W'(HEX_DIGITS);
                     state_in  = ST_SKIP;
                  end
                  OP_BIN: begin
                     letter_in = CH_B_LO;
                     rem_in    = CNT_W'(BIN_DIGITS);
                     state_in  = ST_SKIP;
                  end
                  default: begin
                     letter_in = CH_B_LO;
                     rem_in    = '0;
                     state_in  = ST_SETUP;
                  end
               endcase
            end
         end

         // run the binary to BCD iterations, then commit
         ST_CONV: begin
            if (iter_ff != '0) begin
               dig_ctl.step = 1'b1;
               iter_in      = iter_ff - CNT_W'(1);
            end else begin
               dig_ctl.commit = 1'b1;
               state_in       = ST_SKIP;
            end
         end

         // drop leading zero digits
         ST_SKIP: begin
            if ((rem_ff != '0) && (top_digit == 4'd0)) begin
               dig_ctl.shift = 1'b1;
               rem_in        = rem_ff - CNT_W'(1);
            end else begin
               state_in = ST_CALC;
            end
         end

         // count the padding zeros
         ST_CALC: begin
            if (pg_ff) begin
               zc_in = (prec_ff > len_a) ? prec_ff - len_a : '0;
            end else begin
               zc_in = LEN_W'(defz) + ((tw > len1) ? tw - len1 : '0);
            end
            state_in = ST_SETUP;
         end

         // set the segment boundaries, or give the empty text beat
         ST_SETUP: begin
            b1_in   = LEN_W'(sgn_ff);
            b2_in   = LEN_W'(sgn_ff) + (pfx_ff ? LEN_W'(2) : '0);
            b3_in   = LEN_W'(sgn_ff) + (pfx_ff ? LEN_W'(2) : '0) + zc_ff + LEN_W'(octz_ff);
            n_in    = bad_ff ? '0 : n_calc;
            pos_in  = '0;
            lane_in = 2'd0;
            word_in = '0;
            if (bad_ff || (n_calc == '0)) begin
               rsp_valid_in = 1'b1;
               rsp_text_in  = '0;
               rsp_count_in = 3'd0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end

         // one character a cycle, a beat every four or at the end
         ST_EMIT: begin
            dig_ctl.shift = (pos_ff >= b3_ff);
            pos_in        = pos_ff + LEN_W'(1);
            lane_in       = lane_ff + 2'd1;
            if ((lane_ff == 2'd3) || last_char) begin
               rsp_valid_in = 1'b1;
               rsp_text_in  = word_next;
               rsp_count_in = {1'b0, lane_ff} + 3'd1;
               rsp_last_in  = last_char;
               word_in      = '0;
            end else begin
               word_in = word_next;
            end
            if (last_char) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      bad_ff       <= bad_in;
      sgn_ff       <= sgn_in;
      sign_char_ff <= sign_char_in;
      letter_ff    <= letter_in;
      pfx_ff       <= pfx_in;
      octz_ff      <= octz_in;
      zpad_ff      <= zpad_in;
      pg_ff        <= pg_in;
      prec_ff      <= prec_in;
      width_ff     <= width_in;
      iter_ff      <= iter_in;
      rem_ff       <= rem_in;
      zc_ff        <= zc_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      b3_ff        <= b3_in;
      n_ff         <= n_in;
      pos_ff       <= pos_in;
      lane_ff      <= lane_in;
      word_ff      <= word_in;
      rsp_text_ff  <= rsp_text_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // drive the ports
   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_chars = rsp_text_ff;
   assign rsp_char_count = rsp_count_ff;
   assign rsp_last_group = rsp_last_ff;

`ifndef ASSERT_OFF
   // the final beat leaves the block ready
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_group |-> !busy)
      else $error("final beat while busy");

   // only the final beat may be partly filled
   a_full_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_group |-> rsp_char_count == 3'd4)
      else $error("short beat before the final one");

   // an accepted command makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("command accepted without going busy");

   // emission never runs past the text length
   a_emit_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> pos_ff < n_ff)
      else $error("character position beyond text length");
`endif

endmodule

`default_nettype wire

[design/itf_digit_src.sv]
// ----------------------------------------------------------------------------
// itf_digit_src: digit source for the integer to text formatter
// Converts a magnitude to BCD with one shift-add-3 step a cycle while stepped,
// and keeps the digits of the selected radix left-aligned in a window that
// shifts out one digit a cycle while shifted, most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_digit_src (
   input  wire logic                          clock,
   input  wire itf_pkg::dig_ctl_type          ctl,
   input  wire logic [2:0]                    op,
   input  wire logic [itf_pkg::VALUE_BITS-1:0] mag,
   output logic [3:0]                         top_digit
);
   import itf_pkg::*;

   logic [VALUE_BITS-1:0] bin_ff;
   logic [DEC_BITS-1:0]   bcd_ff;
   logic [DEC_BITS-1:0]   bcd_adj;
   logic [DIG_W-1:0]      dig_ff;

   // add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   // load, convert, commit and shift the digit window
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         bin_ff <= mag;
         bcd_ff <= '0;
         case (op)
            OP_OCT:  dig_ff <= DIG_W'(OCT_BITS'(mag)) << (DIG_W - OCT_BITS);
            OP_BIN:  dig_ff <= DIG_W'(mag) << (DIG_W - VALUE_BITS);
            default: dig_ff <= DIG_W'(HEX_BITS'(mag)) << (DIG_W - HEX_BITS);
         endcase
      end else if (ctl.step) begin
         bcd_ff <= {bcd_adj[DEC_BITS-2:0], bin_ff[VALUE_BITS-1]};
         bin_ff <= bin_ff << 1;
      end else if (ctl.commit) begin
         dig_ff <= DIG_W'(bcd_ff) << (DIG_W - DEC_BITS);
      end else if (ctl.shift) begin
         case (op)
            OP_OCT:  dig_ff <= dig_ff << 3;
            OP_BIN:  dig_ff <= dig_ff << 1;
            default: dig_ff <= dig_ff << 4;
         endcase
      end
   end

   // top digit of the window for the current radix
   always_comb begin
      case (op)
         OP_OCT:  top_digit = {1'b0, dig_ff[DIG_W-1 -: 3]};
         OP_BIN:  top_digit = {3'b000, dig_ff[DIG_W-1]};
         default: top_digit = dig_ff[DIG_W-1 -: 4];
      endcase
   end

endmodule

`default_nettype wire

[sim/integer_to_text_formatter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_formatter_tb: self-checking bench for the integer formatter
// A queue of commands (directed corner cases, then four phases of random
// commands with differing pacing) feeds a clocked driver; a text predictor builds the
// expected ASCII beats on each accepted command, and a clocked monitor
// compares every result strobe against the oldest expected beat.
// ----------------------------------------------------------------------------

module integer_to_text_formatter_tb;

   import itf_pkg::*;

   // codes the block must treat as undefined
   localparam logic [2:0] OP_RSVD6 = 3'd6;
   localparam logic [2:0] OP_RSVD7 = 3'd7;

   // flag bits of a command, packed {left, plus, space, zero, alt}
   localparam logic [4:0] FL_NONE  = 5'b00000;
   localparam logic [4:0] FL_LEFT  = 5'b10000;
   localparam logic [4:0] FL_PLUS  = 5'b01000;
   localparam logic [4:0] FL_SPACE = 5'b00100;
   localparam logic [4:0] FL_ZERO  = 5'b00010;
   localparam logic [4:0] FL_ALT   = 5'b00001;

   localparam string HEX_LOWER = "0123456789abcdef";
   localparam string HEX_UPPER = "0123456789ABCDEF";

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;

   localparam int RESET_CYCLES = 6;
   localparam int TAIL_CYCLES  = 300;
   localparam int LIMIT_NS     = 12_000_000;

   typedef struct {
      logic [2:0]        opcode;
      logic [63:0]       value;
      logic              left;
      logic              plus;
      logic              space;
      logic              zero;
      logic              alt;
      logic signed [7:0] precision;
      logic [6:0]        width;
      int unsigned       idle_pct;
      bit                drain;
   } fmt_cmd_type;

   typedef struct {
      logic [31:0] chars;
      logic [2:0]  count;
      logic        last;
   } text_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [2:0]        req_opcode = OP_SDEC;
   logic [63:0]       req_value_bits = 64'd0;
   logic              req_flag_left = 1'b0;
   logic              req_flag_plus = 1'b0;
   logic              req_flag_space = 1'b0;
   logic              req_flag_zero = 1'b0;
   logic              req_flag_alt = 1'b0;
   logic signed [7:0] req_precision = -8'sd1;
   logic [6:0]        req_field_width = 7'd0;
   logic              rsp_valid;
   logic [31:0]       rsp_text_chars;
   logic [2:0]        rsp_char_count;
   logic              rsp_last_group;

   fmt_cmd_type   cmd_backlog[$];
   fmt_cmd_type   on_offer;
   text_beat_type text_beats_due[$];
   int            fail_count = 0;
   int            cmds_taken = 0;
   int            beats_seen = 0;

   integer_to_text_formatter dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_value_bits  (req_value_bits),
      .req_flag_left   (req_flag_left),
      .req_flag_plus   (req_flag_plus),
      .req_flag_space  (req_flag_space),
      .req_flag_zero   (req_flag_zero),
      .req_flag_alt    (req_flag_alt),
      .req_precision   (req_precision),
      .req_field_width (req_field_width),
      .rsp_valid       (rsp_valid),
      .rsp_text_chars  (rsp_text_chars),
      .rsp_char_count  (rsp_char_count),
      .rsp_last_group  (rsp_last_group)
   );

   // free-running clock
   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #LIMIT_NS;
      $display("[FAIL] regression broken");
      $finish;
   end

   // build the text of one command and queue its beats
   function automatic void format_text(input fmt_cmd_type c);
      byte unsigned  txt[$];
      logic [63:0]   mag;
      logic [7:0]    sign_ch;
      int            prec;
      int            wid;
      int            len;
      int            tw;
      int            n;
      int            groups;
      int            cnt;
      bit            zpad;
      text_beat_type beat;
      mag     = c.value;
      sign_ch = 8'd0;
      prec    = (c.precision < 0) ? -1 : int'(c.precision);
      wid     = int'(c.width);
      if (prec > MAX_PAD) prec = MAX_PAD;
      if (wid > MAX_PAD) wid = MAX_PAD;
      zpad = c.zero && !c.left;

      // undefined codes give the empty text beat
      if (c.opcode > OP_BIN) begin
         beat = '{32'h0, 3'd0, 1'b1};
         text_beats_due.push_back(beat);
         return;
      end

      // pick the sign; negate the magnitude in full width
      if (c.opcode == OP_SDEC) begin
         if (mag[63]) begin
            sign_ch = CH_MINUS;
            mag = ~mag + 64'd1;
         end else if (c.plus) begin
            sign_ch = CH_PLUS;
         end else if (c.space) begin
            sign_ch = CH_SPACE;
         end
      end

      // digits without leading zeros, least significant pushed first
      case (c.opcode)
         OP_SDEC, OP_UDEC: begin
            while (mag != 64'd0) begin
               txt.push_front(CH_ZERO + 8'(mag % 64'd10));
               mag = mag / 64'd10;
            end
            len = txt.size();
         end
         OP_OCT: begin
            while (mag != 64'd0) begin
               txt.push_front(CH_ZERO + {5'b00000, mag[2:0]});
               mag = mag >> 3;
            end
            if (c.alt && (txt.size() == 0 || txt[0] != CH_ZERO)) txt.push_front(CH_ZERO);
            len = txt.size();
         end
         OP_BIN: begin
            while (mag != 64'd0) begin
               txt.push_front(CH_ZERO + {7'b0000000, mag[0]});
               mag = mag >> 1;
            end
            len = txt.size();
            // prefix counted toward the padded length
            if (c.alt && zpad) len += 2;
         end
         default: begin
            while (mag != 64'd0) begin
               txt.push_front((c.opcode == OP_HEXL) ? HEX_LOWER[mag[3:0]]
                                                    : HEX_UPPER[mag[3:0]]);
               mag = mag >> 4;
            end
            len = txt.size();
            if (c.alt && zpad) len += 2;
         end
      endcase

      // without precision zero-pad to width if asked, else pad to precision
      if (prec < 0) begin
         if (len == 0) begin
            txt.push_front(CH_ZERO);
            len = 1;
         end
         if (zpad) begin
            tw = wid;
            if (sign_ch != 8'd0 && tw > 0) tw--;
            while (len < tw) begin
               txt.push_front(CH_ZERO);
               len++;
            end
         end
      end else begin
         while (len < prec) begin
            txt.push_front(CH_ZERO);
            len++;
         end
      end

      // prefix after padding, sign first of all
      if (c.alt && c.opcode >= OP_HEXL) begin
         txt.push_front((c.opcode == OP_HEXL) ? CH_X_LO :
                        ((c.opcode == OP_HEXU) ? CH_X_UP : CH_B_LO));
         txt.push_front(CH_ZERO);
      end
      if (sign_ch != 8'd0) txt.push_front(sign_ch);

      // pack four characters per beat, first in the low byte
      n = txt.size();
      if (n == 0) begin
         beat = '{32'h0, 3'd0, 1'b1};
         text_beats_due.push_back(beat);
         return;
      end
      groups = (n + 3) / 4;
      for (int k = 0; k < groups; k++) begin
         cnt = (n - 4 * k > 4) ? 4 : n - 4 * k;
         beat.chars = 32'h0;
         for (int j = 0; j < cnt; j++) beat.chars[8 * j +: 8] = txt[4 * k + j];
         beat.count = 3'(cnt);
         beat.last  = (k == groups - 1);
         text_beats_due.push_back(beat);
      end
   endfunction

   // append one command to the backlog
   function automatic void add_cmd(input logic [2:0] op, input logic [63:0] value,
                                   input logic [4:0] flags, input int prec,
                                   input int wid, input int unsigned idle_pct,
                                   input bit drain);
      fmt_cmd_type c;
      c.opcode    = op;
      c.value     = value;
      {c.left, c.plus, c.space, c.zero, c.alt} = flags;
      c.precision = 8'(prec);
      c.width     = 7'(wid);
      c.idle_pct  = idle_pct;
      c.drain     = drain;
      cmd_backlog.push_back(c);
   endfunction

   // driver: offer the next command, hold it until taken
   always @(posedge clock) begin : driver
      bit offer;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            format_text(on_offer);
            cmds_taken++;
         end
         offer = (cmd_backlog.size() != 0);
         // drain: wait until no beat is owed and none is on the wire
         if (offer && cmd_backlog[0].drain && (text_beats_due.size() != 0 || rsp_valid))
            offer = 1'b0;
         if (offer && $urandom_range(99) < cmd_backlog[0].idle_pct) offer = 1'b0;
         if (offer) begin
            on_offer = cmd_backlog.pop_front();
            start           <= 1'b1;
            req_opcode      <= on_offer.opcode;
            req_value_bits  <= on_offer.value;
            req_flag_left   <= on_offer.left;
            req_flag_plus   <= on_offer.plus;
            req_flag_space  <= on_offer.space;
            req_flag_zero   <= on_offer.zero;
            req_flag_alt    <= on_offer.alt;
            req_precision   <= on_offer.precision;
            req_field_width <= on_offer.width;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check every result beat against the oldest expectation
   always @(posedge clock) begin : monitor
      text_beat_type want;
      if (!reset && rsp_valid) begin
         if (text_beats_due.size() == 0) begin
            $error("unexpected beat: text_chars %h char_count %0d last_group %0b",
                   rsp_text_chars, rsp_char_count, rsp_last_group);
            fail_count++;
         end else begin
            want = text_beats_due.pop_front();
            beats_seen++;
            if (rsp_text_chars !== want.chars) begin
               $error("text_chars: expected %h, got %h", want.chars, rsp_text_chars);
               fail_count++;
            end
            if (rsp_char_count !== want.count) begin
               $error("char_count: expected %0d, got %0d", want.count, rsp_char_count);
               fail_count++;
            end
            if (rsp_last_group !== want.last) begin
               $error("last_group: expected %0b, got %0b", want.last, rsp_last_group);
               fail_count++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned phase_idle[4];
      logic [2:0]  op;
      logic [63:0] v;
      int          p;
      int          w;
      phase_idle = '{0, 82, 0, 16};

      // directed corners: zero, extremes, signs, prefixes, saturation
      add_cmd(OP_SDEC, 64'd0, FL_NONE, -1, 0, 0, 1'b1);
      add_cmd(OP_SDEC, MOST_NEG, FL_NONE, -1, 0, 0, 1'b0);
      add_cmd(OP_SDEC, ALL_ONES, FL_PLUS, -1, 0, 0, 1'b0);
      add_cmd(OP_SDEC, ~MOST_NEG, FL_PLUS | FL_SPACE, -1, 0, 0, 1'b0);
      add_cmd(OP_SDEC, 64'd5, FL_SPACE | FL_ZERO, -1, 8, 0, 1'b0);
      add_cmd(OP_SDEC, 64'd0, FL_NONE, 0, 0, 0, 1'b0);
      add_cmd(OP_SDEC, 64'd0, FL_PLUS, 0, 0, 0, 1'b0);
      add_cmd(OP_UDEC, ALL_ONES, FL_NONE, -1, 0, 0, 1'b0);
      add_cmd(OP_UDEC, 64'd42, FL_ZERO, 127, 0, 0, 1'b0);
      add_cmd(OP_UDEC, 64'd42, FL_LEFT | FL_ZERO, -1, 127, 0, 1'b0);
      add_cmd(OP_SDEC, ALL_ONES - 64'd4, FL_ZERO, -1, 127, 0, 1'b0);
      add_cmd(OP_OCT, 64'd0, FL_ALT, -1, 0, 0, 1'b0);
      add_cmd(OP_OCT, 64'd8, FL_ALT | FL_ZERO, -1, 10, 0, 1'b0);
      add_cmd(OP_OCT, ALL_ONES, FL_ALT, 30, 0, 0, 1'b0);
      add_cmd(OP_HEXL, 64'd0, FL_ALT | FL_ZERO, -1, 0, 0, 1'b0);
      add_cmd(OP_HEXU, 64'hFF, FL_ALT | FL_ZERO, -1, 10, 0, 1'b0);
      add_cmd(OP_HEXL, 64'hDEAD_BEEF, FL_ALT | FL_ZERO, 6, 0, 0, 1'b0);
      add_cmd(OP_HEXU, ALL_ONES, FL_ALT, 0, 0, 0, 1'b0);
      add_cmd(OP_BIN, ALL_ONES, FL_ALT | FL_ZERO, -1, 120, 0, 1'b0);
      add_cmd(OP_BIN, 64'd0, FL_ALT, -1, 0, 0, 1'b0);
      add_cmd(OP_BIN, 64'd5, FL_NONE, -128, 0, 0, 1'b0);
      add_cmd(OP_RSVD6, 64'h0123_4567_89AB_CDEF, 5'b11111, 5, 5, 0, 1'b0);
      add_cmd(OP_RSVD7, 64'd0, FL_NONE, -1, 0, 0, 1'b0);
      add_cmd(OP_HEXL, 64'd0, FL_ALT, 0, 0, 0, 1'b0);
      add_cmd(OP_SDEC, MOST_NEG, FL_ZERO | FL_PLUS, -1, 127, 0, 1'b0);

      // random phases: unpaced, sparse sender, unpaced again (the receiver
      // cannot stall), lightly paced; each phase opens after a full drain
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < 100; i++) begin
            if ($urandom_range(19) == 0) op = $urandom_range(1) ? OP_RSVD7 : OP_RSVD6;
            else op = 3'($urandom_range(5));
            case ($urandom_range(5))
               0: v = {$urandom, $urandom};
               1: v = 64'($urandom_range(20));
               2: v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
               3: v = $urandom_range(1) ? (ALL_ONES - 64'($urandom_range(9)))
                                        : (MOST_NEG + 64'($urandom_range(9)));
               4: v = 64'($urandom);
               default: v = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            case ($urandom_range(9))
               0, 1, 2, 3: p = -1;
               4, 5: p = int'($signed(8'($urandom)));
               6, 7, 8: p = $urandom_range(12);
               default: p = $urandom_range(127, 100);
            endcase
            w = $urandom_range(1) ? $urandom_range(20) : $urandom_range(127);
            add_cmd(op, v, 5'($urandom), p, w, phase_idle[ph],
                    (i == 0) || ($urandom_range(49) == 0));
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // wait for every command to be taken and every beat to arrive
      @(negedge clock);
      while (cmd_backlog.size() != 0 || start || text_beats_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (text_beats_due.size() != 0) begin
         $error("%0d expected beats never arrived", text_beats_due.size());
         fail_count++;
      end

      $display("Covered %0d commands: all radices, undefined codes, signs, prefixes,",
               cmds_taken);
      $display("padding and saturation, %0d text beats checked under four pacing phases",
               beats_seen);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
